/* design/etud_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package etud_pkg;

  localparam int SwitchW         = 7;
  localparam int StepW           = 20;
  localparam int DigitW          = 4;
  localparam int CountW          = 13;
  localparam int CalcW           = 15;
  localparam int WeightW         = 7;
  localparam int MinW            = 8;
  localparam int SecW            = 6;
  localparam int FractionBitsDef = 16;

  localparam int SecsPerHour = 3600;
  localparam int SecsPerMin  = 60;
  localparam int DigitBase   = 10;
  localparam int TestDigit   = 8;

  // Reciprocal constants: exact quotients over the full input ranges
  localparam int Div60Mul   = 8739;
  localparam int Div60Shift = 19;
  localparam int Div60ProdW = 27;
  localparam int Div10Mul   = 205;
  localparam int Div10Shift = 11;
  localparam int Div10ProdW = 16;

  typedef struct packed {
    logic              test;
    logic [CountW-1:0] count;
  } etud_cnt_t;

  typedef struct packed {
    logic            test;
    logic [MinW-1:0] mins;
    logic [SecW-1:0] secs;
  } etud_ms_t;

  // Thumbwheel weights 1,2,4,8,10,20,40
  function automatic logic [WeightW-1:0] weigh(input logic [SwitchW-1:0] sw);
    logic [WeightW-1:0] s;
    s = WeightW'(sw[3:0]);
    if (sw[4]) s = s + WeightW'(10);
    if (sw[5]) s = s + WeightW'(20);
    if (sw[6]) s = s + WeightW'(40);
    return s;
  endfunction

endpackage

`default_nettype wire

/* design/etud_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface etud_in_if import etud_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               mode_up;
  logic               test_sel;
  logic               abort_reset;
  logic               liftoff_start;
  logic               run_cmd;
  logic               halt_cmd;
  logic               load_cmd;
  logic               clear_cmd;
  logic [SwitchW-1:0] minute_switches;
  logic [SwitchW-1:0] second_switches;
  logic [StepW-1:0]   elapsed_step;

  modport source (
    output valid, mode_up, test_sel, abort_reset, liftoff_start, run_cmd,
           halt_cmd, load_cmd, clear_cmd, minute_switches, second_switches,
           elapsed_step,
    input  ready
  );
  modport sink (
    input  valid, mode_up, test_sel, abort_reset, liftoff_start, run_cmd,
           halt_cmd, load_cmd, clear_cmd, minute_switches, second_switches,
           elapsed_step,
    output ready
  );
endinterface

interface etud_out_if import etud_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DigitW-1:0] minute_tens_digit;
  logic [DigitW-1:0] minute_units_digit;
  logic [DigitW-1:0] second_tens_digit;
  logic [DigitW-1:0] second_units_digit;

  modport source (
    output valid, minute_tens_digit, minute_units_digit, second_tens_digit,
           second_units_digit,
    input  ready
  );
  modport sink (
    input  valid, minute_tens_digit, minute_units_digit, second_tens_digit,
           second_units_digit,
    output ready
  );
endinterface

`default_nettype wire

/* design/etud_tick.sv */
`timescale 1ns / 1ps
`default_nettype none

module etud_tick import etud_pkg::*; #(
  parameter int FractionBits = FractionBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  etud_in_if.sink    in_i,
  output logic       valid_o,
  input  logic       ready_i,
  output etud_cnt_t  cnt_o
);

  localparam int SumW = ((FractionBits > StepW) ? FractionBits : StepW) + 1;

  logic                    valid_q;
  etud_cnt_t               cnt_q, cnt_d;
  logic [FractionBits-1:0] frac_q, frac_d;
  logic                    running_q, running_d;
  logic                    up_q, up_d;
  logic                    forced_q, forced_d;
  logic                    pend_q, pend_d;
  logic                    prev_abort_q, prev_lift_q;

  logic              accept;
  logic              held, lift_now, clear_req, run_rise, block_up;
  logic [SumW-1:0]   sum;
  logic [CalcW-1:0]  dt, t;

  assign in_i.ready = !valid_q || ready_i;
  assign accept     = in_i.valid && in_i.ready;
  assign valid_o    = valid_q;
  assign cnt_o      = cnt_q;

  always_comb begin
    held      = in_i.abort_reset || in_i.liftoff_start;
    lift_now  = in_i.liftoff_start && !in_i.abort_reset;
    clear_req = (!prev_abort_q && in_i.abort_reset) || (!prev_lift_q && lift_now) ||
                (in_i.halt_cmd && held);

    running_d = !(in_i.halt_cmd || in_i.load_cmd || in_i.clear_cmd) &&
                (running_q || in_i.run_cmd || held);
    run_rise  = !running_q && running_d;

    forced_d = !(in_i.clear_cmd || run_rise) && (forced_q || pend_q);
    block_up = !(in_i.mode_up || in_i.test_sel) && run_rise && !forced_d && !held;
    up_d     = !block_up && (up_q || held || run_rise || in_i.mode_up || forced_d);

    sum = SumW'(frac_q) + SumW'(in_i.elapsed_step);
    dt  = CalcW'(sum >> FractionBits);
    t   = '0;

    pend_d       = 1'b0;
    frac_d       = frac_q;
    cnt_d.test   = in_i.test_sel;
    cnt_d.count  = cnt_q.count;

    if (in_i.clear_cmd || clear_req) begin
      cnt_d.count = '0;
      frac_d      = '0;
    end else if (in_i.load_cmd) begin
      cnt_d.count = CountW'(CountW'(weigh(in_i.minute_switches)) * CountW'(SecsPerMin)) +
                    CountW'(weigh(in_i.second_switches));
    end else if (running_d) begin
      frac_d = sum[FractionBits-1:0];
      if (up_d) begin
        t = CalcW'(cnt_q.count) + dt;
        // single wrap per tick
        if (t >= CalcW'(SecsPerHour)) t = t - CalcW'(SecsPerHour);
      end else begin
        t = CalcW'(cnt_q.count) - dt;
        // reflect at or below zero and force up-counting next tick
        if (t[CalcW-1] || t == '0) begin
          t      = -t;
          pend_d = 1'b1;
        end
      end
      cnt_d.count = t[CountW-1:0];
    end else begin
      frac_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= 1'b0;
      cnt_q        <= '0;
      frac_q       <= '0;
      running_q    <= 1'b0;
      up_q         <= 1'b0;
      forced_q     <= 1'b0;
      pend_q       <= 1'b0;
      prev_abort_q <= 1'b0;
      prev_lift_q  <= 1'b0;
    end else begin
      if (in_i.ready) valid_q <= in_i.valid;
      if (accept) begin
        cnt_q        <= cnt_d;
        frac_q       <= frac_d;
        running_q    <= running_d;
        up_q         <= up_d;
        forced_q     <= forced_d;
        pend_q       <= pend_d;
        prev_abort_q <= in_i.abort_reset;
        prev_lift_q  <= lift_now;
      end
    end
  end

endmodule

`default_nettype wire

/* design/etud_div60.sv */
`timescale 1ns / 1ps
`default_nettype none

module etud_div60 import etud_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  etud_cnt_t cnt_i,
  output logic      valid_o,
  input  logic      ready_i,
  output etud_ms_t  ms_o
);

  logic                  valid_q;
  etud_ms_t              ms_q, ms_d;
  logic [Div60ProdW-1:0] prod;
  logic [CountW-1:0]     rem;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign ms_o    = ms_q;

  always_comb begin
    prod      = Div60ProdW'(cnt_i.count) * Div60ProdW'(Div60Mul);
    ms_d.mins = MinW'(prod >> Div60Shift);
    rem       = cnt_i.count - CountW'(CountW'(ms_d.mins) * CountW'(SecsPerMin));
    ms_d.secs = rem[SecW-1:0];
    ms_d.test = cnt_i.test;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) ms_q <= ms_d;
  end

endmodule

`default_nettype wire

/* design/etud_div10.sv */
`timescale 1ns / 1ps
`default_nettype none

module etud_div10 import etud_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  etud_ms_t    ms_i,
  etud_out_if.source  out_o
);

  logic                  valid_q;
  logic [DigitW-1:0]     mt_q, mu_q, st_q, su_q;
  logic [DigitW-1:0]     mt_d, mu_d, st_d, su_d;
  logic [Div10ProdW-1:0] mprod, sprod;
  logic [MinW-1:0]       mrem;
  logic [SecW-1:0]       srem;

  assign ready_o                  = !valid_q || out_o.ready;
  assign out_o.valid              = valid_q;
  assign out_o.minute_tens_digit  = mt_q;
  assign out_o.minute_units_digit = mu_q;
  assign out_o.second_tens_digit  = st_q;
  assign out_o.second_units_digit = su_q;

  always_comb begin
    mprod = Div10ProdW'(ms_i.mins) * Div10ProdW'(Div10Mul);
    sprod = Div10ProdW'(ms_i.secs) * Div10ProdW'(Div10Mul);
    mt_d  = DigitW'(mprod >> Div10Shift);
    st_d  = DigitW'(sprod >> Div10Shift);
    mrem  = ms_i.mins - MinW'(MinW'(mt_d) * MinW'(DigitBase));
    srem  = ms_i.secs - SecW'(SecW'(st_d) * SecW'(DigitBase));
    mu_d  = mrem[DigitW-1:0];
    su_d  = srem[DigitW-1:0];
    // test mode: all eights
    if (ms_i.test) begin
      mt_d = DigitW'(TestDigit);
      mu_d = DigitW'(TestDigit);
      st_d = DigitW'(TestDigit);
      su_d = DigitW'(TestDigit);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      mt_q <= mt_d;
      mu_q <= mu_d;
      st_q <= st_d;
      su_q <= su_d;
    end
  end

endmodule

`default_nettype wire

/* design/event_timer_up_down_mmss_core.sv */
// Event timer with an up/down MM:SS count.
// in_i carries one tick item: panel switch levels, thumbwheel switches and the
// time elapsed since the previous tick (unsigned, FractionBits fraction bits).
// out_o carries one result item per tick: the four MM:SS display digits, or
// all eights while the mode switch is in test.
// Both channels use valid/ready; an item moves on an edge with both high.
// Three registered stages: the tick stage updates the latches, the fraction
// accumulator and the seconds count; the next stage splits the count into
// minutes and seconds by a reciprocal multiply; the last splits each into
// tens and units and drives the output register.
// An item passes through the tick, minute/second and digit registers in turn,
// and one item is taken every cycle while no stall holds the stages. Each stage
// holds its item while the stage after it is full, so a stall on out_o backs up
// to in_i only once all three stages hold an item.
// Reset clears all latches, the count and the fraction accumulator, and empties
// the pipeline.
`timescale 1ns / 1ps
`default_nettype none

module event_timer_up_down_mmss_core import etud_pkg::*; #(
  parameter int FractionBits = FractionBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  etud_in_if.sink    in_i,
  etud_out_if.source out_o
);

  logic      cnt_valid, cnt_ready;
  etud_cnt_t cnt;
  logic      ms_valid, ms_ready;
  etud_ms_t  ms;

  etud_tick #(
    .FractionBits(FractionBits)
  ) u_tick (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .valid_o (cnt_valid),
    .ready_i (cnt_ready),
    .cnt_o   (cnt)
  );

  etud_div60 u_div60 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cnt_valid),
    .ready_o (cnt_ready),
    .cnt_i   (cnt),
    .valid_o (ms_valid),
    .ready_i (ms_ready),
    .ms_o    (ms)
  );

  etud_div10 u_div10 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ms_valid),
    .ready_o (ms_ready),
    .ms_i    (ms),
    .out_o   (out_o)
  );

  a_reset_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.clear_cmd) |=> (cnt.count == '0))
    else $error("timer reset did not clear the count");

  a_secs_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ms_valid |-> (ms.secs < SecW'(SecsPerMin)))
    else $error("seconds field out of range");

  a_split_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_valid && cnt_ready) |=>
      ((CalcW'(ms.mins) * CalcW'(SecsPerMin) + CalcW'(ms.secs)) ==
       CalcW'($past(cnt.count))))
    else $error("minute/second split does not rebuild the count");

  a_out_fed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ms_valid && ms_ready) |=> out_o.valid)
    else $error("item lost before output register");

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import etud_pkg::*;

  localparam int FracBits    = FractionBitsDef;
  localparam int RandomTicks = 1200;
  localparam int LongHold    = 300;
  localparam int StallLimit  = 4000;
  localparam int PrintCap    = 40;
  localparam int ThumbWeight [SwitchW] = '{1, 2, 4, 8, 10, 20, 40};

  typedef struct packed {
    bit               mode_up;
    bit               test_sel;
    bit               abort_reset;
    bit               liftoff_start;
    bit               run_cmd;
    bit               halt_cmd;
    bit               load_cmd;
    bit               clear_cmd;
    bit [SwitchW-1:0] minute_switches;
    bit [SwitchW-1:0] second_switches;
    bit [StepW-1:0]   elapsed_step;
  } tick_t;

  typedef struct packed {
    logic [DigitW-1:0] minute_tens;
    logic [DigitW-1:0] minute_units;
    logic [DigitW-1:0] second_tens;
    logic [DigitW-1:0] second_units;
  } digits_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  etud_in_if  in_if ();
  etud_out_if out_if ();

  event_timer_up_down_mmss_core u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk = ~clk;

  // Timer state as the display logic should see it
  logic [CountW-1:0]   sec_count;
  logic [FracBits-1:0] frac_acc;
  bit run_latch, up_latch, forced_up_latch, force_up_next;
  bit run_seen, abort_seen, liftoff_seen;

  tick_t   tick_plan [$];
  digits_t digits_due [$];
  tick_t   on_bus;
  digits_t seen, want;

  bit offering, long_stall_req, long_stall_done;
  int send_gap, send_calm, drain_hold, drain_calm, drain_roll;
  int n_accepted, n_results, n_errors, n_directed, n_planned;
  int n_zero_cross, n_hour_wraps, n_test_ticks;
  int in_wait, in_wait_max, quiet_cycles;

  function automatic int thumbwheel(input bit [SwitchW-1:0] sw);
    int s;
    s = 0;
    for (int i = 0; i < SwitchW; i++) begin
      if (sw[i]) s += ThumbWeight[i];
    end
    return s;
  endfunction

  function automatic digits_t advance_timer(input tick_t t);
    digits_t d;
    bit down_sel, held, abort_rise, lift_now, lift_rise, clear_now, start_rise, block_up;
    logic [31:0] sum;
    int whole, cnt, mins, secs;
    down_sel   = !(t.mode_up || t.test_sel);
    held       = t.abort_reset || t.liftoff_start;
    abort_rise = !abort_seen && t.abort_reset;
    // liftoff only counts while abort is low
    lift_now   = t.liftoff_start && !t.abort_reset;
    lift_rise  = !liftoff_seen && lift_now;
    abort_seen   = t.abort_reset;
    liftoff_seen = lift_now;
    clear_now  = abort_rise || lift_rise || (t.halt_cmd && held);

    run_latch  = !(t.halt_cmd || t.load_cmd || t.clear_cmd) &&
                 (run_latch || t.run_cmd || held);
    start_rise = !run_seen && run_latch;
    run_seen   = run_latch;

    forced_up_latch = !(t.clear_cmd || start_rise) && (forced_up_latch || force_up_next);
    force_up_next   = 1'b0;
    block_up = down_sel && start_rise && !forced_up_latch && !held;
    up_latch = !block_up &&
               (up_latch || held || start_rise || t.mode_up || forced_up_latch);

    if (t.clear_cmd || clear_now) begin
      sec_count = '0;
      frac_acc  = '0;
    end else if (t.load_cmd) begin
      // load leaves the fraction alone
      sec_count = CountW'(thumbwheel(t.minute_switches) * SecsPerMin +
                          thumbwheel(t.second_switches));
    end else if (run_latch) begin
      sum      = 32'(frac_acc) + 32'(t.elapsed_step);
      whole    = int'(sum >> FracBits);
      frac_acc = sum[FracBits-1:0];
      cnt      = int'(sec_count);
      if (up_latch) begin
        cnt += whole;
        if (cnt >= SecsPerHour) begin
          cnt -= SecsPerHour;
          n_hour_wraps++;
        end
      end else begin
        cnt -= whole;
        // reflect through zero and count up from the next tick
        if (cnt <= 0) begin
          cnt = -cnt;
          force_up_next = 1'b1;
          n_zero_cross++;
        end
      end
      sec_count = CountW'(cnt);
    end else begin
      frac_acc = '0;
    end

    if (t.test_sel) begin
      n_test_ticks++;
      d.minute_tens  = DigitW'(TestDigit);
      d.minute_units = DigitW'(TestDigit);
      d.second_tens  = DigitW'(TestDigit);
      d.second_units = DigitW'(TestDigit);
    end else begin
      mins = int'(sec_count) / SecsPerMin;
      secs = int'(sec_count) % SecsPerMin;
      d.minute_tens  = DigitW'(mins / DigitBase);
      d.minute_units = DigitW'(mins % DigitBase);
      d.second_tens  = DigitW'(secs / DigitBase);
      d.second_units = DigitW'(secs % DigitBase);
    end
    return d;
  endfunction

  task automatic report_mismatch(input string msg);
    n_errors++;
    if (n_errors <= PrintCap) $display("[%0t] ERROR result %0d: %s", $time, n_results, msg);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic bit [StepW-1:0] rand_step();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 6) return StepW'($urandom_range(0, 32'h1FFFF));
    return StepW'($urandom());
  endfunction

  // {test, up}; mostly down or up
  function automatic bit [1:0] pick_mode();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 2'b00;
    if (r < 8) return 2'b01;
    if (r < 9) return 2'b10;
    return 2'b11;
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    logic [31:0] r;
    r = $urandom();
    {t.mode_up, t.test_sel, t.abort_reset, t.liftoff_start} = r[3:0];
    {t.run_cmd, t.halt_cmd, t.load_cmd, t.clear_cmd} = r[7:4];
    t.minute_switches = r[14:8];
    t.second_switches = r[21:15];
    t.elapsed_step    = StepW'($urandom());
    return t;
  endfunction

  // An optional load, a start, then a run with occasional panel events; some noise bursts
  function automatic void add_session();
    tick_t t;
    bit [1:0] mode;
    int len, r, abort_left, lift_left;
    abort_left = 0;
    lift_left  = 0;
    if ($urandom_range(0, 9) < 2) begin
      len = $urandom_range(3, 10);
      repeat (len) tick_plan.push_back(random_tick());
      return;
    end
    mode = pick_mode();
    if ($urandom_range(0, 3) != 0) begin
      t = '0;
      {t.test_sel, t.mode_up} = mode;
      t.load_cmd = 1'b1;
      t.minute_switches = ($urandom_range(0, 9) < 6) ? '0 : SwitchW'($urandom());
      t.second_switches = SwitchW'($urandom());
      t.elapsed_step = rand_step();
      tick_plan.push_back(t);
    end
    t = '0;
    {t.test_sel, t.mode_up} = mode;
    t.run_cmd      = 1'b1;
    t.elapsed_step = rand_step();
    tick_plan.push_back(t);
    len = $urandom_range(4, 40);
    repeat (len) begin
      t = '0;
      if ($urandom_range(0, 19) == 0) mode = pick_mode();
      {t.test_sel, t.mode_up} = mode;
      t.elapsed_step = rand_step();
      r = $urandom_range(0, 99);
      if (r < 3) abort_left = $urandom_range(1, 6);
      else if (r < 6) lift_left = $urandom_range(1, 6);
      else if (r < 9) t.halt_cmd = 1'b1;
      else if (r < 10) begin
        t.load_cmd = 1'b1;
        t.minute_switches = SwitchW'($urandom());
        t.second_switches = SwitchW'($urandom());
      end else if (r < 11) t.clear_cmd = 1'b1;
      else if (r < 14) t.run_cmd = 1'b1;
      t.abort_reset   = (abort_left > 0);
      t.liftoff_start = (lift_left > 0);
      if (abort_left > 0) abort_left--;
      if (lift_left > 0) lift_left--;
      tick_plan.push_back(t);
    end
  endfunction

  // Sender: hold each item until taken, then wait out a random gap
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && !in_if.ready) in_wait++;
      else in_wait = 0;
      if (in_wait > in_wait_max) in_wait_max = in_wait;
      if (in_if.valid && in_if.ready) begin
        digits_due.push_back(advance_timer(on_bus));
        n_accepted++;
        offering = 1'b0;
      end
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
          in_if.valid <= 1'b0;
        end else if (tick_plan.size() > 0) begin
          on_bus = tick_plan.pop_front();
          in_if.valid           <= 1'b1;
          in_if.mode_up         <= on_bus.mode_up;
          in_if.test_sel        <= on_bus.test_sel;
          in_if.abort_reset     <= on_bus.abort_reset;
          in_if.liftoff_start   <= on_bus.liftoff_start;
          in_if.run_cmd         <= on_bus.run_cmd;
          in_if.halt_cmd        <= on_bus.halt_cmd;
          in_if.load_cmd        <= on_bus.load_cmd;
          in_if.clear_cmd       <= on_bus.clear_cmd;
          in_if.minute_switches <= on_bus.minute_switches;
          in_if.second_switches <= on_bus.second_switches;
          in_if.elapsed_step    <= on_bus.elapsed_step;
          offering = 1'b1;
          if (send_calm > 0) begin
            send_calm--;
            send_gap = 0;
          end else begin
            if ($urandom_range(0, 49) == 0) send_calm = 60;
            send_gap = pick_gap();
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, calm stretches, and one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (long_stall_req && !long_stall_done) begin
      long_stall_done = 1'b1;
      drain_hold = LongHold;
      out_if.ready <= 1'b0;
    end else if (drain_hold > 0) begin
      drain_hold--;
      out_if.ready <= 1'b0;
    end else if (drain_calm > 0) begin
      drain_calm--;
      out_if.ready <= 1'b1;
    end else begin
      drain_roll = pick_gap();
      if ($urandom_range(0, 49) == 0) begin
        drain_calm = 60;
        out_if.ready <= 1'b1;
      end else if (drain_roll == 0) begin
        out_if.ready <= 1'b1;
      end else begin
        drain_hold = drain_roll - 1;
        out_if.ready <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      seen.minute_tens  = out_if.minute_tens_digit;
      seen.minute_units = out_if.minute_units_digit;
      seen.second_tens  = out_if.second_tens_digit;
      seen.second_units = out_if.second_units_digit;
      if (digits_due.size() == 0) begin
        report_mismatch("result with no tick outstanding");
      end else begin
        want = digits_due.pop_front();
        if (seen.minute_tens !== want.minute_tens)
          report_mismatch($sformatf("minute_tens_digit got %0d want %0d",
                                    seen.minute_tens, want.minute_tens));
        if (seen.minute_units !== want.minute_units)
          report_mismatch($sformatf("minute_units_digit got %0d want %0d",
                                    seen.minute_units, want.minute_units));
        if (seen.second_tens !== want.second_tens)
          report_mismatch($sformatf("second_tens_digit got %0d want %0d",
                                    seen.second_tens, want.second_tens));
        if (seen.second_units !== want.second_units)
          report_mismatch($sformatf("second_units_digit got %0d want %0d",
                                    seen.second_units, want.second_units));
      end
      n_results++;
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("Timeout: no item moved for %0d cycles, %0d ticks still due",
               StallLimit, digits_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    tick_t t;
    in_if.valid           = 1'b0;
    in_if.mode_up         = 1'b0;
    in_if.test_sel        = 1'b0;
    in_if.abort_reset     = 1'b0;
    in_if.liftoff_start   = 1'b0;
    in_if.run_cmd         = 1'b0;
    in_if.halt_cmd        = 1'b0;
    in_if.load_cmd        = 1'b0;
    in_if.clear_cmd       = 1'b0;
    in_if.minute_switches = '0;
    in_if.second_switches = '0;
    in_if.elapsed_step    = '0;
    out_if.ready          = 1'b0;

    // idle in mode down, then test display
    t = '0; tick_plan.push_back(t);
    t = '0; t.test_sel = 1'b1; tick_plan.push_back(t);
    // largest thumbwheel load, then count up through the hour wrap
    t = '0; t.load_cmd = 1'b1; t.minute_switches = '1; t.second_switches = '1;
    t.elapsed_step = '1; tick_plan.push_back(t);
    t = '0; t.mode_up = 1'b1; t.run_cmd = 1'b1; t.elapsed_step = '1;
    tick_plan.push_back(t);
    t = '0; t.mode_up = 1'b1; t.elapsed_step = '1; tick_plan.push_back(t);
    t = '0; tick_plan.push_back(t);
    // load 0:05, count down to exactly zero, then forced up
    t = '0; t.load_cmd = 1'b1; t.second_switches = 7'b0000101; tick_plan.push_back(t);
    t = '0; t.run_cmd = 1'b1; t.elapsed_step = 20'h20000; tick_plan.push_back(t);
    t = '0; t.elapsed_step = 20'h30000; tick_plan.push_back(t);
    t = '0; t.elapsed_step = 20'h10000; tick_plan.push_back(t);
    t = '0; t.halt_cmd = 1'b1; t.elapsed_step = 20'h10000; tick_plan.push_back(t);
    // load 0:02, overshoot zero and reflect
    t = '0; t.load_cmd = 1'b1; t.second_switches = 7'b0000010; tick_plan.push_back(t);
    t = '0; t.run_cmd = 1'b1; t.elapsed_step = 20'h50000; tick_plan.push_back(t);
    // abort edge, abort held with liftoff, liftoff edge, stop while held
    t = '0; t.abort_reset = 1'b1; t.elapsed_step = 20'h08000; tick_plan.push_back(t);
    t.liftoff_start = 1'b1; t.elapsed_step = 20'h18000; tick_plan.push_back(t);
    t = '0; t.liftoff_start = 1'b1; t.elapsed_step = 20'h18000; tick_plan.push_back(t);
    t.elapsed_step = 20'h24000; tick_plan.push_back(t);
    t.halt_cmd = 1'b1; tick_plan.push_back(t);
    t = '0; t.clear_cmd = 1'b1; t.run_cmd = 1'b1; t.minute_switches = 7'h40;
    tick_plan.push_back(t);
    // a load in mid-run keeps the fraction
    t = '0; t.load_cmd = 1'b1; t.minute_switches = 7'h10; tick_plan.push_back(t);
    t = '0; t.mode_up = 1'b1; t.run_cmd = 1'b1; t.elapsed_step = 20'h0C000;
    tick_plan.push_back(t);
    t = '0; t.mode_up = 1'b1; t.load_cmd = 1'b1; t.second_switches = 7'h01;
    tick_plan.push_back(t);
    t = '0; t.mode_up = 1'b1; t.run_cmd = 1'b1; t.elapsed_step = 20'h0C000;
    tick_plan.push_back(t);
    t = '0; t.test_sel = 1'b1; t.elapsed_step = 20'h10000; tick_plan.push_back(t);
    t = '0; t.elapsed_step = '0; tick_plan.push_back(t);
    n_directed = tick_plan.size();

    while (tick_plan.size() < n_directed + RandomTicks) add_session();
    n_planned = tick_plan.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (n_accepted < n_planned / 4) @(posedge clk);
    @(negedge clk);
    long_stall_req = 1'b1;

    while (n_accepted < n_planned) @(posedge clk);
    while (digits_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d ticks (%0d directed), checked %0d digit sets, %0d test-mode ticks.",
             n_accepted, n_directed, n_results, n_test_ticks);
    $display("Down counts through zero: %0d, hour wraps: %0d, longest input stall: %0d cycles.",
             n_zero_cross, n_hour_wraps, in_wait_max);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
